### sv/msl_pkg.sv
// Shared types, codes and constants of the MFM sector locator.
// Holds the CRC-16-CCITT byte step used by the datapath.
`default_nettype none

package msl_pkg;

  localparam logic [7:0]  SYNC_BYTE = 8'hA1;
  localparam logic [7:0]  ID_MARK   = 8'hFE;
  localparam logic [7:0]  DATA_MARK = 8'hFB;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam int          BASE_SIZE = 128;
  localparam int          LEFT_W    = 11;

  typedef enum logic [1:0] {
    REG_CYLINDER = 2'd0,
    REG_HEAD     = 2'd1,
    REG_SECTOR   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_DATA         = 2'd0,
    KIND_NO_ID        = 2'd1,
    KIND_NO_DATA_MARK = 2'd2
  } kind_t;

  typedef enum logic [6:0] {
    PH_FIND_ID     = 7'b0000001,
    PH_CAPTURE     = 7'b0000010,
    PH_SEEK_WANTED = 7'b0000100,
    PH_SEEK_OTHER  = 7'b0001000,
    PH_EMIT        = 7'b0010000,
    PH_SKIP        = 7'b0100000,
    PH_DONE        = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] cylinder;
    logic [7:0] head;
    logic [7:0] sector;
  } target_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sector_byte;
    logic        last_of_sector;
    logic [15:0] sector_crc;
    logic        mark_repaired;
  } result_t;

  // MSB-first CRC-16-CCITT over one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after A1 A1 A1 FB
  localparam logic [15:0] CRC_AFTER_MARK =
    crc16_step(crc16_step(crc16_step(crc16_step(CRC_INIT, SYNC_BYTE), SYNC_BYTE),
                          SYNC_BYTE), DATA_MARK);

endpackage

`default_nettype wire

### sv/msl_cfg.sv
// Target ID registers of the MFM sector locator.
// Depends on msl_pkg for the register indexes and the target struct.
`default_nettype none

module msl_cfg
  import msl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output target_t         target
);

  target_t target_r;
  target_t target_nxt;

  assign cfg_ready = 1'b1;
  assign target    = target_r;

  always_comb begin
    target_nxt = target_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CYLINDER: target_nxt.cylinder = cfg_data;
        REG_HEAD:     target_nxt.head     = cfg_data;
        REG_SECTOR:   target_nxt.sector   = cfg_data;
        default:      target_nxt          = target_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '{cylinder: 8'd0, head: 8'd0, sector: 8'd1};
    end else begin
      target_r <= target_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/msl_step.sv
// Track scan state and per-byte step logic of the MFM sector locator.
// Depends on msl_pkg for the phase codes, CRC step and result struct.
`default_nettype none

module msl_step
  import msl_pkg::*;
#(
  parameter int TRACK_BYTES = 6400,
  parameter int SCAN_LIMIT  = 6250
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire logic [7:0] track_byte,
  input  wire logic       track_start,
  input  wire target_t    target,
  output logic            res_valid,
  output result_t         res
);

  localparam int OFS_W      = $clog2(TRACK_BYTES);
  localparam int SEARCH_END = (SCAN_LIMIT + 3 > TRACK_BYTES) ? TRACK_BYTES : SCAN_LIMIT + 3;
  localparam logic [OFS_W-1:0] LAST_SCAN = OFS_W'(SEARCH_END - 1);
  localparam logic [OFS_W-1:0] LAST_OFS  = OFS_W'(TRACK_BYTES - 1);

  phase_t             phase_r,  phase_nxt;
  logic [OFS_W-1:0]   ofs_r,    ofs_nxt;
  logic [23:0]        recent_r, recent_nxt;
  logic [1:0]         fidx_r,   fidx_nxt;
  logic [LEFT_W-1:0]  left_r,   left_nxt;
  logic [15:0]        crc_r,    crc_nxt;
  logic               rep_r,    rep_nxt;

  logic       hit;
  logic       last;
  logic       match;
  logic [7:0] want;

  always_comb begin
    phase_nxt  = phase_r;
    ofs_nxt    = ofs_r;
    recent_nxt = recent_r;
    fidx_nxt   = fidx_r;
    left_nxt   = left_r;
    crc_nxt    = crc_r;
    rep_nxt    = rep_r;
    res_valid  = 1'b0;
    res        = '0;
    hit        = 1'b0;
    last       = 1'b0;
    want       = ID_MARK;
    match      = (recent_r[23:16] == target.cylinder) && (recent_r[15:8] == target.head) &&
                 (recent_r[7:0] == target.sector);

    if (track_start) begin
      phase_nxt  = PH_FIND_ID;
      ofs_nxt    = '0;
      recent_nxt = '0;
      fidx_nxt   = '0;
      left_nxt   = '0;
      crc_nxt    = CRC_INIT;
      rep_nxt    = 1'b0;
    end

    if (phase_nxt != PH_DONE) begin
      case (phase_nxt)
        PH_EMIT: begin
          crc_nxt = crc16_step(crc_nxt, track_byte);
          if (left_nxt != '0) begin
            left_nxt = left_nxt - LEFT_W'(1);
          end
          last = (left_nxt == '0);
          res_valid = 1'b1;
          res.kind = KIND_DATA;
          res.sector_byte = track_byte;
          res.last_of_sector = last;
          res.sector_crc = last ? crc_nxt : 16'h0000;
          if (last) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_SKIP: begin
          if (left_nxt != '0) begin
            left_nxt = left_nxt - LEFT_W'(1);
          end
          if (left_nxt == '0) begin
            phase_nxt = PH_FIND_ID;
            fidx_nxt  = '0;
          end
        end
        default: begin
          if (phase_nxt == PH_CAPTURE) begin
            if (fidx_nxt == 2'd3) begin
              left_nxt  = LEFT_W'(BASE_SIZE) << track_byte[1:0];
              phase_nxt = (match && !track_start) ? PH_SEEK_WANTED : PH_SEEK_OTHER;
            end else begin
              fidx_nxt = fidx_nxt + 2'd1;
            end
          end
          if (phase_nxt == PH_FIND_ID || phase_nxt == PH_SEEK_WANTED ||
              phase_nxt == PH_SEEK_OTHER) begin
            want = (phase_nxt == PH_FIND_ID) ? ID_MARK : DATA_MARK;
            hit  = (fidx_nxt == 2'd3) && (ofs_nxt <= LAST_SCAN) &&
                   (recent_nxt[15:0] == {SYNC_BYTE, SYNC_BYTE}) && (track_byte == want);
            if (hit) begin
              if (recent_nxt[23:16] != SYNC_BYTE) begin
                rep_nxt = 1'b1;
              end
              if (phase_nxt == PH_FIND_ID) begin
                phase_nxt = PH_CAPTURE;
                fidx_nxt  = '0;
              end else if (phase_nxt == PH_SEEK_WANTED) begin
                crc_nxt   = CRC_AFTER_MARK;
                phase_nxt = PH_EMIT;
              end else begin
                left_nxt  = left_nxt + LEFT_W'(2);
                phase_nxt = PH_SKIP;
              end
            end else begin
              if (fidx_nxt != 2'd3) begin
                fidx_nxt = fidx_nxt + 2'd1;
              end
              if (ofs_nxt >= LAST_SCAN) begin
                res_valid = 1'b1;
                res.kind  = (phase_nxt == PH_SEEK_WANTED) ? KIND_NO_DATA_MARK : KIND_NO_ID;
                phase_nxt = PH_DONE;
              end
            end
          end
        end
      endcase

      recent_nxt = {recent_nxt[15:0], track_byte};
      if (ofs_nxt >= LAST_OFS) begin
        phase_nxt = PH_DONE;
      end else begin
        ofs_nxt = ofs_nxt + OFS_W'(1);
      end
    end

    res.mark_repaired = rep_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIND_ID;
      ofs_r    <= '0;
      recent_r <= '0;
      fidx_r   <= '0;
      left_r   <= '0;
      crc_r    <= CRC_INIT;
      rep_r    <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      ofs_r    <= ofs_nxt;
      recent_r <= recent_nxt;
      fidx_r   <= fidx_nxt;
      left_r   <= left_nxt;
      crc_r    <= crc_nxt;
      rep_r    <= rep_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/mfm_sector_locator.sv
// MFM sector locator: takes one decoded track byte per clock through a one-entry input
// register, steps the scan state and places any result in a one-entry output register.
// A byte is taken every cycle while out_tready stays high; its result is registered in
// the output register (result channel) as the byte leaves the input register; the rate
// is set by the single per-byte step (mark compare, one CRC byte update) between them.
// Depends on msl_pkg, msl_cfg and msl_step.
`default_nettype none

module mfm_sector_locator
  import msl_pkg::*;
#(
  parameter int TRACK_BYTES = 6400,
  parameter int SCAN_LIMIT  = 6250
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] track_byte
  input  wire logic        in_tuser,   // [0] track_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] sector_byte, [23:8] sector_crc,
                                       // [24] mark_repaired, [31:25] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,  // last_of_sector
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  target_t    target;
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  logic       advance;
  logic       in_xfer;
  logic       res_valid;
  result_t    res;

  msl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .target    (target)
  );

  msl_step #(
    .TRACK_BYTES (TRACK_BYTES),
    .SCAN_LIMIT  (SCAN_LIMIT)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .track_byte  (in_byte_r),
    .track_start (in_start_r),
    .target      (target),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || out_tready) begin
      out_valid_nxt = advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.mark_repaired, out_res_r.sector_crc,
                       out_res_r.sector_byte};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last_of_sector;

endmodule

`default_nettype wire

### sv/msl_checker.sv
// Port-level checks of the MFM sector locator result channel, bound to the top level.
// Depends on msl_pkg for the result kind codes.
`default_nettype none

module msl_checker
  import msl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_DATA)
    else $error("last_of_sector on a status result");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |-> out_tdata[23:0] == 24'd0)
    else $error("status result carries data");

  a_crc_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[23:8] == 16'd0 && out_tdata[31:25] == 7'd0)
    else $error("CRC shown before the final byte");

endmodule

bind mfm_sector_locator msl_checker u_msl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### bench/tb_top.sv
// Testbench for mfm_sector_locator: builds track images of ID marks, data marks and sectors,
// predicts each result in a scoreboard class and checks the output stream against it.
// Depends on msl_pkg and mfm_sector_locator.
`timescale 1ns / 100ps

module tb_top
  import msl_pkg::*;
();

  localparam int TRACK_LEN = 6400;
  localparam int SCAN_LEN  = 6250;

  class sector_tracker;
    int          track_len;
    int          scan_len;
    logic [7:0]  tgt_cyl;
    logic [7:0]  tgt_head;
    logic [7:0]  tgt_sec;
    logic [12:0] track_pos;
    phase_t      scan_phase;
    logic [23:0] last_three;
    logic [31:0] id_bytes;
    logic [1:0]  field_cnt;
    logic [10:0] bytes_to_go;
    logic [15:0] data_crc;
    logic        lead_fixed;
    result_t     pending_out[$];
    int          errors;

    function new(int tlen, int slen);
      track_len = tlen;
      scan_len  = slen;
      tgt_cyl   = 8'h00;
      tgt_head  = 8'h00;
      tgt_sec   = 8'h01;
      errors    = 0;
      clear_track();
    endfunction

    function void clear_track();
      track_pos   = '0;
      scan_phase  = PH_FIND_ID;
      last_three  = '0;
      id_bytes    = '0;
      field_cnt   = '0;
      bytes_to_go = '0;
      data_crc    = CRC_INIT;
      lead_fixed  = 1'b0;
    endfunction

    function void set_target(cfg_reg_t idx, logic [7:0] val);
      case (idx)
        REG_CYLINDER: tgt_cyl = val;
        REG_HEAD:     tgt_head = val;
        REG_SECTOR:   tgt_sec = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void add_result(kind_t k, logic [7:0] d, logic l, logic [15:0] c);
      result_t r;
      r.kind           = k;
      r.sector_byte    = d;
      r.last_of_sector = l;
      r.sector_crc     = c;
      r.mark_repaired  = lead_fixed;
      pending_out.push_back(r);
    endfunction

    function void take_track_byte(logic [7:0] b, logic start);
      int         pos;
      int         scan_end;
      logic       hit;
      logic       match;
      logic       last;
      logic [7:0] want;
      if (start) clear_track();
      if (scan_phase == PH_DONE) return;
      pos = int'(track_pos);
      scan_end = scan_len + 3;
      if (scan_end > track_len) scan_end = track_len;

      if (scan_phase == PH_EMIT) begin
        data_crc = crc_byte(data_crc, b);
        if (bytes_to_go != 0) bytes_to_go--;
        last = (bytes_to_go == 0);
        add_result(KIND_DATA, b, last, last ? data_crc : 16'h0000);
        if (last) scan_phase = PH_DONE;
      end else if (scan_phase == PH_SKIP) begin
        if (bytes_to_go != 0) bytes_to_go--;
        if (bytes_to_go == 0) begin
          scan_phase = PH_FIND_ID;
          field_cnt = '0;
        end
      end else begin
        if (scan_phase == PH_CAPTURE) begin
          id_bytes = {id_bytes[23:0], b};
          if (field_cnt == 2'd3) begin
            match = id_bytes[31:24] == tgt_cyl && id_bytes[23:16] == tgt_head &&
                    id_bytes[15:8] == tgt_sec;
            bytes_to_go = 11'(BASE_SIZE << b[1:0]);
            scan_phase = match ? PH_SEEK_WANTED : PH_SEEK_OTHER;
          end else begin
            field_cnt++;
          end
        end
        if (scan_phase == PH_FIND_ID || scan_phase == PH_SEEK_WANTED ||
            scan_phase == PH_SEEK_OTHER) begin
          want = (scan_phase == PH_FIND_ID) ? ID_MARK : DATA_MARK;
          hit = field_cnt == 2'd3 && pos < scan_end &&
                last_three[15:0] == {SYNC_BYTE, SYNC_BYTE} && b == want;
          if (hit) begin
            if (last_three[23:16] != SYNC_BYTE) lead_fixed = 1'b1;
            if (scan_phase == PH_FIND_ID) begin
              scan_phase = PH_CAPTURE;
              field_cnt = '0;
            end else if (scan_phase == PH_SEEK_WANTED) begin
              data_crc = crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, SYNC_BYTE),
                                  SYNC_BYTE), SYNC_BYTE), DATA_MARK);
              scan_phase = PH_EMIT;
            end else begin
              bytes_to_go = bytes_to_go + 11'd2;
              scan_phase = PH_SKIP;
            end
          end else begin
            if (field_cnt != 2'd3) field_cnt++;
            if (pos + 1 >= scan_end) begin
              add_result((scan_phase == PH_SEEK_WANTED) ? KIND_NO_DATA_MARK : KIND_NO_ID,
                         8'h00, 1'b0, 16'h0000);
              scan_phase = PH_DONE;
            end
          end
        end
      end

      last_three = {last_three[15:0], b};
      if (pos + 1 >= track_len) scan_phase = PH_DONE;
      else track_pos = 13'(pos + 1);
    endfunction

    function void compare_result(result_t got);
      result_t exp;
      if (pending_out.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result kind %0d byte %02h last %0b crc %04h rep %0b",
                   $time, got.kind, got.sector_byte, got.last_of_sector, got.sector_crc,
                   got.mark_repaired);
        return;
      end
      exp = pending_out.pop_front();
      if (got.kind !== exp.kind || got.sector_byte !== exp.sector_byte ||
          got.last_of_sector !== exp.last_of_sector || got.sector_crc !== exp.sector_crc ||
          got.mark_repaired !== exp.mark_repaired) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp %0d %02h %0b %04h %0b, got %0d %02h %0b %04h %0b",
                   $time, exp.kind, exp.sector_byte, exp.last_of_sector, exp.sector_crc,
                   exp.mark_repaired, got.kind, got.sector_byte, got.last_of_sector,
                   got.sector_crc, got.mark_repaired);
      end
    endfunction

    function int pending();
      return pending_out.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [7:0]  cfg_data;

  sector_tracker tracker;
  logic [7:0]    track_q[$];
  logic [7:0]    tgt_c, tgt_h, tgt_s;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_left;
  logic          hold_req;
  int            sent_count;

  mfm_sector_locator #(
    .TRACK_BYTES(TRACK_LEN),
    .SCAN_LIMIT (SCAN_LEN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // result receiver: random stalls plus a single long hold
  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && in_tvalid && in_tready) tracker.take_track_byte(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) begin
      got.kind           = kind_t'(out_tuser);
      got.sector_byte    = out_tdata[7:0];
      got.sector_crc     = out_tdata[23:8];
      got.mark_repaired  = out_tdata[24];
      got.last_of_sector = out_tlast;
      tracker.compare_result(got);
    end
  end

  function void add_byte(logic [7:0] b);
    track_q.push_back(b);
  endfunction

  function void add_noise(int n);
    repeat (n) add_byte(($urandom_range(0, 7) == 0) ? SYNC_BYTE : 8'($urandom));
  endfunction

  // never produces a sync byte, so no mark can form
  function void add_filler(int n);
    repeat (n) add_byte(8'($urandom_range(0, 160)));
  endfunction

  function void add_data(int n);
    repeat (n) add_byte(8'($urandom));
  endfunction

  function void add_id(logic [7:0] lead, logic [7:0] c, logic [7:0] h, logic [7:0] s,
                       logic [7:0] code);
    add_byte(lead);
    add_byte(SYNC_BYTE);
    add_byte(SYNC_BYTE);
    add_byte(ID_MARK);
    add_byte(c);
    add_byte(h);
    add_byte(s);
    add_byte(code);
  endfunction

  function void add_data_mark(logic [7:0] lead);
    add_byte(lead);
    add_byte(SYNC_BYTE);
    add_byte(SYNC_BYTE);
    add_byte(DATA_MARK);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic start);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_track();
    for (int i = 0; i < track_q.size(); i++) push_byte(track_q[i], i == 0);
    track_q.delete();
  endtask

  // hold the input and let every pending result drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_target(idx, val);
    @(negedge clk);
  endtask

  task automatic write_targets(input logic [7:0] c, input logic [7:0] h, input logic [7:0] s);
    write_reg(REG_CYLINDER, c);
    write_reg(REG_HEAD, h);
    write_reg(REG_SECTOR, s);
    cfg_valid <= 1'b0;
    tgt_c = c;
    tgt_h = h;
    tgt_s = s;
  endtask

  task automatic build_random_track();
    int         r;
    int         sz;
    int         keep;
    logic [7:0] c, h, s, lead;
    add_noise($urandom_range(0, 12));
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 99);
      c = tgt_c;
      h = tgt_h;
      s = tgt_s;
      if (r >= 45 && r < 75) begin
        case ($urandom_range(0, 2))
          0: c = c ^ (8'd1 << $urandom_range(0, 7));
          1: h = h ^ (8'd1 << $urandom_range(0, 7));
          default: s = s ^ (8'd1 << $urandom_range(0, 7));
        endcase
      end else if (r >= 75) begin
        c = 8'($urandom);
        h = 8'($urandom);
        s = 8'($urandom);
      end
      r = $urandom_range(0, 99);
      sz = (r < 65) ? 0 : (r < 85) ? 1 : (r < 95) ? 2 : 3;
      lead = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SYNC_BYTE;
      add_id(lead, c, h, s, {6'($urandom), 2'(sz)});
      add_noise($urandom_range(0, 20));
      lead = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SYNC_BYTE;
      if ($urandom_range(0, 9) == 0) begin
        add_byte(lead);
        add_byte(SYNC_BYTE);
        add_byte(SYNC_BYTE ^ (8'd1 << $urandom_range(0, 7)));
        add_byte(DATA_MARK);
      end else begin
        add_data_mark(lead);
      end
      add_data((BASE_SIZE << sz) + 2);
    end
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, track_q.size());
      while (track_q.size() > keep) void'(track_q.pop_back());
    end
  endtask

  initial begin
    int phase_sent;
    tracker = new(TRACK_LEN, SCAN_LEN);
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_CYLINDER;
    cfg_data = 8'h00;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    sent_count = 0;
    tgt_c = 8'h00;
    tgt_h = 8'h00;
    tgt_s = 8'h01;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset targets: plain sector, with the receiver held off long enough to fill the block
    hold_req = 1'b1;
    add_noise(6);
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h01, 8'h00);
    add_noise(22);
    add_data_mark(SYNC_BYTE);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_data(128);
    send_track();

    // partial ID matches are skipped; a mark right after a skip with a bad lead
    add_id(SYNC_BYTE, 8'h00, 8'h05, 8'h01, 8'h00);
    add_noise(3);
    add_data_mark(SYNC_BYTE);
    add_data(128);
    add_byte(SYNC_BYTE);
    add_byte(SYNC_BYTE);
    add_byte(ID_MARK);
    add_noise(2);
    add_id(SYNC_BYTE, 8'h07, 8'h00, 8'h01, 8'h01);
    add_data_mark(SYNC_BYTE);
    add_data(258);
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h02, 8'h00);
    add_data_mark(SYNC_BYTE);
    add_data(130);
    add_id(8'h00, 8'h00, 8'h00, 8'h01, 8'h01);
    add_noise(4);
    add_data_mark(8'h4E);
    add_data(258);
    send_track();

    // sync bytes before a track start must not pair with the first byte
    add_noise(4);
    add_byte(SYNC_BYTE);
    add_byte(SYNC_BYTE);
    send_track();
    add_byte(ID_MARK);
    add_noise(3);
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h01, 8'h02);
    add_data_mark(SYNC_BYTE);
    add_data(514);
    send_track();

    // data mark whose lead is the cylinder field
    settle();
    write_targets(8'hFF, SYNC_BYTE, SYNC_BYTE);
    add_noise(5);
    add_id(SYNC_BYTE, 8'hFF, SYNC_BYTE, SYNC_BYTE, DATA_MARK);
    add_data(1030);
    send_track();

    settle();
    write_targets(8'h00, 8'h00, 8'h00);
    // no ID mark anywhere
    add_filler(6300);
    send_track();
    // wanted ID without a data mark
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);
    add_filler(6300);
    send_track();
    // other ID without a data mark
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h09, 8'h01);
    add_filler(6300);
    send_track();
    // last data mark inside the window; sector cut by the track end
    add_filler(6200);
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h03);
    add_filler(41);
    add_data_mark(SYNC_BYTE);
    add_data(220);
    send_track();
    // first data mark outside the window
    add_filler(6200);
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h03);
    add_filler(42);
    add_data_mark(SYNC_BYTE);
    add_data(10);
    send_track();
    // skip cut by the track end
    add_filler(6000);
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h05, 8'h03);
    add_filler(5);
    add_data_mark(SYNC_BYTE);
    add_data(420);
    send_track();
    // sector cut by a new track, then a complete one
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);
    add_data_mark(SYNC_BYTE);
    add_data(60);
    send_track();
    add_id(SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);
    add_noise(3);
    add_data_mark(SYNC_BYTE);
    add_data(130);
    send_track();

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: write_targets(8'hFF, 8'hFF, 8'hFF);
        1: write_targets(8'h00, 8'h00, 8'h00);
        default: write_targets(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 36 : 0;
      phase_sent = sent_count;
      while (sent_count - phase_sent < 500) begin
        build_random_track();
        send_track();
      end
    end

    in_tvalid <= 1'b0;
    for (int i = 0; i < 20000 && tracker.pending() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    tracker.errors += tracker.pending();
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### mfm_sector_locator.f
sv/msl_pkg.sv
sv/msl_cfg.sv
sv/msl_step.sv
sv/mfm_sector_locator.sv
sv/msl_checker.sv
bench/tb_top.sv
